>>> design/write_admission_limit_controller_top_macros.svh
// Assertion macros for the write admission limit controller RTL.
// Each macro checks a property on the rising edge of clk; WAL_ASSERT stays
// quiet while the synchronous reset is asserted, WAL_ASSERT_ALWAYS does not.
`ifndef WRITE_ADMISSION_LIMIT_CONTROLLER_TOP_MACROS_SVH
`define WRITE_ADMISSION_LIMIT_CONTROLLER_TOP_MACROS_SVH

// Clocked check that is masked during reset.
`define WAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define WAL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> design/wal_pkg.sv
// ----------------------------------------------------------------------------
// Write admission limit controller package
// Shared types, device-kind codes and thresholds for the limit controller.
// ----------------------------------------------------------------------------
`default_nettype none

package wal_pkg;

  // Default window length and hold-off period.
  localparam int WAL_WINDOW_DEF  = 16;
  localparam int WAL_HOLDOFF_DEF = 30000000;

  // Field widths.
  localparam int ELAPSED_W = 32;
  localparam int TIME_W    = 48;
  localparam int LIMIT_W   = 4;
  localparam int KIND_W    = 2;
  // Counters are seven bits wide and hold a window of up to 127 samples.
  localparam int CNT_W     = 7;

  // Device kind codes; the unused code behaves like the other kind.
  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HDD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SSD   = 2'd2;

  // Latency thresholds in microseconds.
  localparam logic [ELAPSED_W-1:0] HDD_SLOW_US   = 32'd30000;
  localparam logic [ELAPSED_W-1:0] OTHER_SLOW_US = 32'd20000;
  localparam logic [ELAPSED_W-1:0] HDD_FAST_US   = 32'(30000 / 4);
  localparam logic [ELAPSED_W-1:0] OTHER_FAST_US = 32'(20000 / 4);

  // Limits per device kind.
  localparam logic [LIMIT_W-1:0] INIT_SSD   = 4'd4;
  localparam logic [LIMIT_W-1:0] INIT_OTHER = 4'd2;
  localparam logic [LIMIT_W-1:0] MAX_HDD    = 4'd4;
  localparam logic [LIMIT_W-1:0] MAX_SSD    = 4'd8;
  localparam logic [LIMIT_W-1:0] MAX_OTHER  = 4'd2;
  localparam logic [LIMIT_W-1:0] LIMIT_FLOOR = 4'd1;

  // Window decision thresholds.
  localparam logic [CNT_W-1:0] SLOW_TRIP = 7'd8;
  localparam logic [CNT_W-1:0] FAST_TRIP = 7'd14;

  // Adjustment reported with each result.
  typedef enum logic [1:0] {
    ADJ_NONE  = 2'd0,
    ADJ_HALVE = 2'd1,
    ADJ_RAISE = 2'd2
  } adj_t;

  // One registered write completion, with its precomputed hold-off deadline.
  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    logic                 room;
    logic [TIME_W-1:0]    now;
    logic [TIME_W-1:0]    deadline;
  } wal_sample_t;

  // One result of the limit update.
  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic               closed;
    adj_t               adj;
  } wal_result_t;

endpackage

`default_nettype wire

>>> design/write_admission_limit_controller_top.sv
// ----------------------------------------------------------------------------
// Write admission limit controller
// Adaptive write-concurrency limit for one storage device, one result per
// completed write.
// ----------------------------------------------------------------------------
// The block takes one write completion per clock while the output is not
// stalled, as the core updates the limit and window counters per request,
// and returns one result per request, in order. A request is registered with
// its hold-off deadline on acceptance; the core applies the limit update as
// it leaves the input register, and the output register takes the result
// at the end of that cycle. The output register holds a finished result
// under stall while the input register can still take one more request.
// The device kind register must be written only while the block is idle;
// the block itself does not enforce this. No clearing pass follows reset.
`default_nettype none

module write_admission_limit_controller_top #(
  parameter int WINDOW_SAMPLES = wal_pkg::WAL_WINDOW_DEF,
  parameter int HOLDOFF_US     = wal_pkg::WAL_HOLDOFF_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [wal_pkg::KIND_W-1:0]    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [wal_pkg::ELAPSED_W-1:0] elapsed_us,
  input  wire logic                          has_room,
  input  wire logic [wal_pkg::TIME_W-1:0]    now_us,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [wal_pkg::LIMIT_W-1:0]        concurrency_limit,
  output logic                               window_closed,
  output logic [1:0]                         adjustment
);
  import wal_pkg::*;

  logic        s1_valid;
  wal_sample_t s1_sample;
  wal_result_t core_result;
  wal_result_t out_result;
  logic        accept;
  logic        advance;

  // Handshake: the input register moves on when the output register is free.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Input register with the hold-off deadline computed on the way in.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample.elapsed  <= elapsed_us;
      s1_sample.room     <= has_room;
      s1_sample.now      <= now_us;
      s1_sample.deadline <= now_us + TIME_W'(HOLDOFF_US);
    end
  end

  wal_core #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (advance),
    .sample      (s1_sample),
    .result      (core_result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign concurrency_limit = out_result.limit;
  assign window_closed     = out_result.closed;
  assign adjustment        = out_result.adj;

endmodule

`default_nettype wire

>>> design/wal_core.sv
// ----------------------------------------------------------------------------
// Limit update core
// Holds the device kind, the limit, the hold-off deadline and the window
// counters, and applies one write completion per step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "write_admission_limit_controller_top_macros.svh"

module wal_core #(
  parameter int WINDOW_SAMPLES = wal_pkg::WAL_WINDOW_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [wal_pkg::KIND_W-1:0]  cfg_wr_data,
  input  wire logic                        step,
  input  wire wal_pkg::wal_sample_t        sample,
  output wal_pkg::wal_result_t             result
);
  import wal_pkg::*;

  localparam logic [CNT_W-1:0] WINDOW_CNT = CNT_W'(WINDOW_SAMPLES);

  logic [KIND_W-1:0]  disk_kind;
  logic [LIMIT_W-1:0] current_limit;
  logic [TIME_W-1:0]  allowed_at;
  logic [CNT_W-1:0]   sample_count;
  logic [CNT_W-1:0]   fast_count;
  logic [CNT_W-1:0]   slow_count;

  logic [LIMIT_W-1:0] current_limit_next;
  logic [TIME_W-1:0]  allowed_at_next;
  logic [CNT_W-1:0]   sample_count_next;
  logic [CNT_W-1:0]   fast_count_next;
  logic [CNT_W-1:0]   slow_count_next;

  // Per-kind constants and the next state for the sample in the input register.
  always_comb begin
    logic               is_hdd;
    logic               is_ssd;
    logic [LIMIT_W-1:0] init_lim;
    logic [LIMIT_W-1:0] max_lim;
    logic [ELAPSED_W-1:0] slow_thr;
    logic [ELAPSED_W-1:0] fast_thr;
    logic [LIMIT_W-1:0] lim0;
    logic [TIME_W-1:0]  allowed0;
    logic [LIMIT_W-1:0] half;
    logic [LIMIT_W:0]   up;
    logic [CNT_W-1:0]   cnt_s;
    logic [CNT_W-1:0]   cnt_f;
    logic [CNT_W-1:0]   cnt_l;

    is_hdd   = (disk_kind == KIND_HDD);
    is_ssd   = (disk_kind == KIND_SSD);
    init_lim = is_ssd ? INIT_SSD : INIT_OTHER;
    max_lim  = is_hdd ? MAX_HDD : (is_ssd ? MAX_SSD : MAX_OTHER);
    slow_thr = is_hdd ? HDD_SLOW_US : OTHER_SLOW_US;
    fast_thr = is_hdd ? HDD_FAST_US : OTHER_FAST_US;

    // The first sample after reset starts the limit and the hold-off.
    if (current_limit == '0) begin
      lim0     = init_lim;
      allowed0 = sample.deadline;
    end else begin
      lim0     = current_limit;
      allowed0 = allowed_at;
    end

    cnt_s = sample_count + CNT_W'(1);
    cnt_f = fast_count + CNT_W'(sample.elapsed < fast_thr);
    cnt_l = slow_count + CNT_W'(sample.elapsed >= slow_thr);

    half = lim0 >> 1;
    up   = {1'b0, lim0} + (LIMIT_W+1)'(1);

    current_limit_next = lim0;
    allowed_at_next    = allowed0;
    sample_count_next  = cnt_s;
    fast_count_next    = cnt_f;
    slow_count_next    = cnt_l;
    result.limit       = lim0;
    result.closed      = 1'b0;
    result.adj         = ADJ_NONE;

    // Window decision: halve on congestion or no room, otherwise raise when fast enough and the hold-off has passed.
    if (cnt_s >= WINDOW_CNT) begin
      result.closed     = 1'b1;
      sample_count_next = '0;
      fast_count_next   = '0;
      slow_count_next   = '0;
      if ((cnt_l >= SLOW_TRIP) || !sample.room) begin
        current_limit_next = (half == '0) ? LIMIT_FLOOR : half;
        allowed_at_next    = sample.deadline;
        result.adj         = ADJ_HALVE;
      end else if ((cnt_f >= FAST_TRIP) && (sample.now >= allowed0)) begin
        current_limit_next = (up > {1'b0, max_lim}) ? max_lim : up[LIMIT_W-1:0];
        allowed_at_next    = sample.deadline;
        result.adj         = ADJ_RAISE;
      end
      result.limit = current_limit_next;
    end
  end

  // Device kind register.
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_kind <= KIND_OTHER;
    end else if (cfg_wr_en) begin
      disk_kind <= cfg_wr_data;
    end
  end

  // Limit state, advanced once per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_limit <= '0;
      allowed_at    <= '0;
      sample_count  <= '0;
      fast_count    <= '0;
      slow_count    <= '0;
    end else if (step) begin
      current_limit <= current_limit_next;
      allowed_at    <= allowed_at_next;
      sample_count  <= sample_count_next;
      fast_count    <= fast_count_next;
      slow_count    <= slow_count_next;
    end
  end

  `WAL_ASSERT(a_limit_started, step |=> (current_limit != '0), "limit is zero after a sample")
  `WAL_ASSERT(a_limit_range, current_limit <= MAX_SSD, "limit above the largest maximum")
  `WAL_ASSERT(a_window_bound, sample_count < WINDOW_CNT, "sample count reached the window")
  `WAL_ASSERT(a_close_clears, (step && result.closed) |=> ((sample_count == '0) && (fast_count == '0) && (slow_count == '0)), "window close left counts")
  `WAL_ASSERT(a_adj_needs_close, (result.adj != ADJ_NONE) |-> result.closed, "adjustment without window close")

endmodule

`default_nettype wire
